[sv/ack_retransmit_tracker_defines.svh]
// assertion macros for the ack retransmit tracker
`ifndef ACK_RETRANSMIT_TRACKER_DEFINES_SVH
`define ACK_RETRANSMIT_TRACKER_DEFINES_SVH

// property that must hold at every edge out of reset
`define ART_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on the following edge
`define ART_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/art_pkg.sv]
// ----------------------------------------------------------------------------
// art_pkg
// shared types and constants of the ack retransmit tracker
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int SLOTS_DEF = 8;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [2:0] RETRY_RESET = 3'd3;
  localparam logic [15:0] NO_EXPIRY = 16'hFFFF;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_ACK = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [0:0] REG_TIMEOUT = 1'd0;
  localparam logic [0:0] REG_RETRY = 1'd1;

  localparam logic [2:0] KIND_ADDED = 3'd0;
  localparam logic [2:0] KIND_MATCH = 3'd1;
  localparam logic [2:0] KIND_UNMATCHED = 3'd2;
  localparam logic [2:0] KIND_RETX = 3'd3;
  localparam logic [2:0] KIND_SUMMARY = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_ACK_SCAN,
    ST_TICK_SCAN,
    ST_EMIT,
    ST_SUMMARY
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the request
    logic pos_clear;  // walk pointer to list head
    logic step;       // evaluate list entry at pointer
    logic emit;       // load the output register
    logic add_commit; // append the added slot
    logic bad_ack;    // count an unmatched ack
    logic summary;    // load the tick summary
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       slot_ok;
    logic       at_end;    // pointer past last pending entry
    logic       hit;       // entry at pointer is of interest
    logic       out_busy;  // output register holds a result
  } status_t;

endpackage

[sv/art_ctrl.sv]
// ----------------------------------------------------------------------------
// art_ctrl
// sequencer that walks the send-order list for each request
// ----------------------------------------------------------------------------
module art_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  art_pkg::status_t status,
  output art_pkg::cmd_t    cmd
);
  import art_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_IDLE;
          case (status.op)
            OP_ADD: state_next = ST_ADD_SCAN;
            OP_ACK: state_next = ST_ACK_SCAN;
            OP_TICK: state_next = ST_TICK_SCAN;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD_SCAN: begin
        if (!status.slot_ok) state_next = ST_IDLE;
        else if ((status.at_end || status.hit) && !status.out_busy) state_next = ST_IDLE;
      end
      ST_ACK_SCAN: begin
        if ((status.at_end || status.hit) && !status.out_busy) state_next = ST_IDLE;
      end
      ST_TICK_SCAN: begin
        if (status.at_end) begin
          if (!status.out_busy) state_next = ST_IDLE;
        end else if (status.hit && !status.out_busy) begin
          state_next = ST_TICK_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        cmd.pos_clear = in_valid;
      end
      ST_ADD_SCAN: begin
        // drop the stale list entry, then append once output is free
        if (status.slot_ok && !status.out_busy) begin
          if (status.at_end || status.hit) begin
            cmd.add_commit = 1'b1;
            cmd.emit = 1'b1;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      ST_ACK_SCAN: begin
        if (!status.out_busy) begin
          if (status.hit) begin
            cmd.step = 1'b1;
            cmd.emit = 1'b1;
          end else if (status.at_end) begin
            cmd.bad_ack = 1'b1;
            cmd.emit = 1'b1;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      ST_TICK_SCAN: begin
        if (status.at_end) begin
          if (!status.out_busy) begin
            cmd.summary = 1'b1;
            cmd.emit = 1'b1;
          end
        end else if (status.hit) begin
          if (!status.out_busy) begin
            cmd.step = 1'b1;
            cmd.emit = 1'b1;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

[sv/art_dpath.sv]
// ----------------------------------------------------------------------------
// art_dpath
// entry table, send-order list, counters and output register
// ----------------------------------------------------------------------------
module art_dpath #(
  parameter int SLOTS = art_pkg::SLOTS_DEF,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic [1:0]       in_op,
  input  logic [2:0]       in_slot,
  input  logic [15:0]      in_seq,
  input  logic [3:0]       in_ver,
  input  logic [15:0]      in_elapsed,
  input  art_pkg::cmd_t    cmd,
  output art_pkg::status_t status,
  output logic             m_valid,
  input  logic             m_ready,
  output logic [2:0]       o_kind,
  output logic [2:0]       o_slot,
  output logic [15:0]      o_seq,
  output logic             o_dropped,
  output logic [15:0]      o_expiry,
  output logic [31:0]      o_no_ack,
  output logic [31:0]      o_bad_ack,
  output logic             o_last
);
  import art_pkg::*;

  logic [15:0] timeout_ms;
  logic [2:0]  retry_limit;

  logic [SLOTS-1:0] entry_valid;
  logic [15:0] entry_seq [SLOTS];
  logic [3:0]  entry_version [SLOTS];
  logic [15:0] entry_remaining [SLOTS];
  logic [2:0]  entry_retries [SLOTS];
  logic [IW-1:0] send_order [SLOTS];
  logic [CW-1:0] pending_count;
  logic [31:0] no_ack_counter, bad_ack_counter;

  logic [1:0]  r_op;
  logic [2:0]  r_slot;
  logic [15:0] r_seq;
  logic [3:0]  r_ver;
  logic [15:0] r_elapsed;
  logic [CW-1:0] pos;
  logic [15:0] least;

  logic [IW-1:0] cur;
  logic [15:0] cur_rem;
  logic [2:0]  cur_retry_dec;
  logic        cur_valid, expired, ack_hit, add_hit, at_end, slot_ok, hit;
  logic        remove; // unlink list position pos on this step
  logic [IW-1:0] slot_ix;
  logic [15:0] new_rem;

  logic [2:0]  e_kind, e_slot;
  logic [15:0] e_seq, e_expiry;
  logic        e_dropped, e_last;
  logic [31:0] e_no_ack, e_bad_ack;

  assign at_end = (pos >= pending_count) || (pos >= CW'(SLOTS));
  assign cur = send_order[pos[IW-1:0]];
  assign cur_valid = entry_valid[cur];
  assign cur_rem = entry_remaining[cur];
  assign cur_retry_dec = (entry_retries[cur] == 3'd0) ? 3'd0 : entry_retries[cur] - 3'd1;
  assign expired = cur_rem <= r_elapsed;
  assign ack_hit = cur_valid && entry_seq[cur] == r_seq && entry_version[cur] == r_ver;
  assign slot_ok = {29'd0, r_slot} < 32'(SLOTS);
  assign slot_ix = IW'(r_slot);
  assign add_hit = cur == slot_ix;
  assign new_rem = expired ? timeout_ms : cur_rem - r_elapsed;

  // the list position past the end holds stale data, so nothing hits there
  always_comb begin
    hit = 1'b0;
    if (!at_end) begin
      case (r_op)
        OP_ADD: hit = add_hit;
        OP_ACK: hit = ack_hit;
        OP_TICK: hit = cur_valid && expired;
        default: hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    remove = 1'b0;
    if (cmd.step && !at_end) begin
      case (r_op)
        OP_ACK: remove = ack_hit;
        OP_TICK: remove = !cur_valid || (expired && cur_retry_dec == 3'd0);
        default: remove = 1'b0;
      endcase
    end
  end

  assign status.op = cmd.load ? in_op : r_op;
  assign status.slot_ok = slot_ok;
  assign status.at_end = at_end;
  assign status.hit = hit;
  assign status.out_busy = m_valid && !m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
      retry_limit <= RETRY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT: timeout_ms <= cfg_data;
        REG_RETRY: retry_limit <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_op <= in_op;
      r_slot <= in_slot;
      r_seq <= in_seq;
      r_ver <= in_ver;
      r_elapsed <= in_elapsed;
      least <= NO_EXPIRY;
    end
    if (cmd.step && !at_end && r_op == OP_TICK && cur_valid &&
        !(expired && cur_retry_dec == 3'd0)) begin
      entry_remaining[cur] <= new_rem;
      if (new_rem < least) least <= new_rem;
    end
    if (cmd.step && !at_end && r_op == OP_TICK && cur_valid && expired)
      entry_retries[cur] <= cur_retry_dec;
    if (cmd.add_commit) begin
      entry_seq[slot_ix] <= r_seq;
      entry_version[slot_ix] <= r_ver;
      entry_remaining[slot_ix] <= timeout_ms;
      entry_retries[slot_ix] <= (retry_limit == 3'd0) ? 3'd1 : retry_limit;
    end
  end

  // list shift: the whole tail moves down one position when a gap is closed
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      pending_count <= '0;
      pos <= '0;
    end else begin
      if (cmd.pos_clear) begin
        pos <= '0;
      end else if (cmd.step && !at_end) begin
        if (remove) begin
          // shift the tail down in one go over narrow entries
          for (int i = 0; i < SLOTS - 1; i++)
            if (CW'(i) >= pos) send_order[i] <= send_order[i + 1];
          pending_count <= pending_count - CW'(1);
        end else begin
          pos <= pos + CW'(1);
        end
        if (r_op == OP_ACK && ack_hit) entry_valid[cur] <= 1'b0;
        if (r_op == OP_TICK && cur_valid && expired && cur_retry_dec == 3'd0)
          entry_valid[cur] <= 1'b0;
      end
      if (cmd.add_commit) begin
        entry_valid[slot_ix] <= 1'b1;
        if (!at_end && add_hit) begin
          // close the gap below the tail, then put the slot at the tail
          for (int i = 0; i < SLOTS - 1; i++)
            if (CW'(i) >= pos && CW'(i + 1) < pending_count)
              send_order[i] <= send_order[i + 1];
          send_order[pending_count[IW-1:0] - IW'(1)] <= slot_ix;
        end else if (pending_count < CW'(SLOTS)) begin
          send_order[pending_count[IW-1:0]] <= slot_ix;
          pending_count <= pending_count + CW'(1);
        end
      end
    end
  end

  always_comb begin
    e_kind = KIND_RETX;
    e_slot = 3'(cur);
    e_seq = entry_seq[cur];
    e_dropped = 1'b0;
    e_expiry = '0;
    e_no_ack = no_ack_counter;
    e_bad_ack = bad_ack_counter;
    e_last = 1'b1;
    if (cmd.summary) begin
      e_kind = KIND_SUMMARY;
      e_slot = '0;
      e_seq = '0;
      e_expiry = least;
    end else if (cmd.bad_ack) begin
      e_kind = KIND_UNMATCHED;
      e_slot = '0;
      e_seq = r_seq;
      e_bad_ack = bad_ack_counter + 32'd1;
    end else if (cmd.add_commit) begin
      e_kind = KIND_ADDED;
      e_slot = r_slot;
      e_seq = r_seq;
    end else if (r_op == OP_ACK) begin
      e_kind = KIND_MATCH;
      e_seq = r_seq;
    end else begin
      // a retransmit is never the final result of a tick
      e_last = 1'b0;
      if (cur_retry_dec == 3'd0) begin
        e_dropped = 1'b1;
        e_no_ack = no_ack_counter + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      no_ack_counter <= '0;
      bad_ack_counter <= '0;
      m_valid <= 1'b0;
    end else begin
      m_valid <= cmd.emit || (m_valid && !m_ready);
      if (cmd.emit) begin
        no_ack_counter <= e_no_ack;
        bad_ack_counter <= e_bad_ack;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_kind <= e_kind;
      o_slot <= e_slot;
      o_seq <= e_seq;
      o_dropped <= e_dropped;
      o_expiry <= e_expiry;
      o_no_ack <= e_no_ack;
      o_bad_ack <= e_bad_ack;
      o_last <= e_last;
    end
  end

endmodule

[sv/ack_retransmit_tracker.sv]
// ack_retransmit_tracker
// Keeps up to SLOTS frames awaiting acknowledgement in send order.
// Requests arrive on s_axis (add, ack, tick); results leave on m_axis,
// tlast marking the final result of each request. Configuration is
// written through cfg_we/cfg_index/cfg_data; the user must do so only
// while the block is idle, as the block itself does not enforce it.
// One request is handled at a time: the controller walks the send-order
// list one entry a cycle while no stalled receiver holds it. An add
// with a valid slot ends by appending it, an ack with a match or an
// unmatched result and a tick with a summary, after its retransmits.
// Each result sits in the output register until taken; a stalled
// receiver holds the walk at the next result and s_axis_tready stays
// low. Reset clears the valid bits, list length and counters, and loads
// timeout 1000 ms and retry limit 3; the table needs no clearing pass.
// ----------------------------------------------------------------------------
// ack_retransmit_tracker
// retransmission timer with acknowledgement matching, top level
// ----------------------------------------------------------------------------
`include "ack_retransmit_tracker_defines.svh"
module ack_retransmit_tracker #(
  parameter int SLOTS = art_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slot[2:0], seq_number[18:3], frame_version[22:19], elapsed_ms[38:23], pad
  input  logic [39:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_slot[2:0], out_seq[18:3], dropped[19], next_expiry_ms[35:20],
  // no_ack_total[67:36], bad_ack_total[99:68], pad
  output logic [103:0] m_axis_tdata,
  // kind[2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import art_pkg::*;

  cmd_t cmd;
  status_t status;
  logic [2:0] o_slot;
  logic [15:0] o_seq, o_expiry;
  logic o_dropped;
  logic [31:0] o_no_ack, o_bad_ack;
  logic walk_start;

  art_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .status(status), .cmd(cmd)
  );

  art_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_op(s_axis_tuser), .in_slot(s_axis_tdata[2:0]), .in_seq(s_axis_tdata[18:3]),
    .in_ver(s_axis_tdata[22:19]), .in_elapsed(s_axis_tdata[38:23]),
    .cmd(cmd), .status(status), .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
    .o_kind(m_axis_tuser), .o_slot(o_slot), .o_seq(o_seq), .o_dropped(o_dropped),
    .o_expiry(o_expiry), .o_no_ack(o_no_ack), .o_bad_ack(o_bad_ack),
    .o_last(m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, o_bad_ack, o_no_ack, o_expiry, o_dropped, o_seq, o_slot};

  // adds and acks always walk the list before the next request
  assign walk_start = cmd.load && (status.op == OP_ADD || status.op == OP_ACK);

  `ART_ASSERT(a_ready_idle, !(s_axis_tready && cmd.emit), "emit while idle")
  `ART_ASSERT(a_no_emit_busy, !(cmd.emit && m_axis_tvalid && !m_axis_tready), "result overwritten")
  `ART_ASSERT_NEXT(a_load_busy, walk_start, !s_axis_tready, "request finished without result")

endmodule
